FILE: rtl/cfp_pkg.sv
// Package for the command frame parser: transaction types, phase codes,
// register indexes and fixed constants. No dependencies.
`default_nettype none

package cfp_pkg;

    localparam int unsigned NUM_COMMANDS = 5;
    localparam int unsigned MAX_PAYLOAD  = 4;
    localparam int unsigned LEN_REGS     = 5;

    localparam logic [7:0] SYNC_BYTE = 8'h21;

    typedef logic [2:0] len_t;
    typedef logic [2:0] cfg_index_t;

    localparam len_t LEN_RESET [LEN_REGS] = '{3'd0, 3'd4, 3'd0, 3'd0, 3'd0};

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CMD     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] argument;
    } result_t;

    typedef struct packed {
        logic    fire;
        result_t res;
    } step_out_t;

endpackage

`default_nettype wire

FILE: rtl/cfp_len_regs.sv
// Payload length registers, one per command, with the lookup that clamps
// the length to the largest payload. Depends on cfp_pkg.
`default_nettype none

module cfp_len_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire cfp_pkg::cfg_index_t cfg_index,
    input  wire cfp_pkg::len_t      cfg_data,
    input  wire logic [2:0]         cmd,
    output cfp_pkg::len_t           len
);

    cfp_pkg::len_t len_reg [cfp_pkg::LEN_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(cfp_pkg::LEN_REGS); i++)
            begin
                len_reg[cfp_pkg::cfg_index_t'(i)] <=
                    cfp_pkg::LEN_RESET[cfp_pkg::cfg_index_t'(i)];
            end
        end
        else if (cfg_we && (32'(cfg_index) < cfp_pkg::LEN_REGS))
        begin
            len_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        cfp_pkg::len_t raw;
        raw = '0;
        if (32'(cmd) < cfp_pkg::LEN_REGS)
        begin
            raw = len_reg[cmd];
        end
        if (32'(raw) > cfp_pkg::MAX_PAYLOAD)
        begin
            len = cfp_pkg::len_t'(cfp_pkg::MAX_PAYLOAD);
        end
        else
        begin
            len = raw;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfp_frame_fsm.sv
// Frame recognition state machine: sync hunt, command, payload assembly and
// checksum check, one byte per step. Depends on cfp_pkg.
`default_nettype none

module cfp_frame_fsm (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire cfp_pkg::item_t item,
    output logic [2:0]          len_cmd,
    input  wire cfp_pkg::len_t  len,
    output cfp_pkg::step_out_t  step_out
);

    cfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      cmd_reg, cmd_next;
    logic [7:0]      sum_reg, sum_next;
    logic [2:0]      left_reg, left_next;
    logic [1:0]      idx_reg, idx_next;
    logic [31:0]     word_reg, word_next;
    logic [2:0]      left_dec;
    logic [7:0]      b;

    assign b       = item.rx_byte;
    assign len_cmd = b[2:0];
    assign left_dec = (left_reg != 3'd0) ? (left_reg - 3'd1) : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        if (item.mode)
        begin
            phase_next = cfp_pkg::PH_HUNT;
        end
        else
        begin
            case (phase_reg)
                cfp_pkg::PH_SYNC2:
                begin
                    phase_next = (b == cfp_pkg::SYNC_BYTE) ? cfp_pkg::PH_CMD : cfp_pkg::PH_HUNT;
                end
                cfp_pkg::PH_CMD:
                begin
                    if (32'(b) < cfp_pkg::NUM_COMMANDS)
                    begin
                        cmd_next   = b[2:0];
                        sum_next   = b;
                        left_next  = len;
                        idx_next   = 2'd0;
                        word_next  = '0;
                        phase_next = (len != 3'd0) ? cfp_pkg::PH_PAYLOAD : cfp_pkg::PH_CHECK;
                    end
                    else
                    begin
                        phase_next = cfp_pkg::PH_HUNT;
                    end
                end
                cfp_pkg::PH_PAYLOAD:
                begin
                    case (idx_reg)
                        2'd0:    word_next = word_reg | {24'd0, b};
                        2'd1:    word_next = word_reg | {16'd0, b, 8'd0};
                        2'd2:    word_next = word_reg | {8'd0, b, 16'd0};
                        default: word_next = word_reg | {b, 24'd0};
                    endcase
                    sum_next  = sum_reg + b;
                    idx_next  = idx_reg + 2'd1;
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        phase_next = cfp_pkg::PH_CHECK;
                    end
                end
                cfp_pkg::PH_CHECK:
                begin
                    phase_next = cfp_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = (b == cfp_pkg::SYNC_BYTE) ? cfp_pkg::PH_SYNC2 : cfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        step_out.fire         = !item.mode && (phase_reg == cfp_pkg::PH_CHECK) && (b == sum_reg);
        step_out.res.command  = cmd_reg;
        step_out.res.argument = word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfp_pkg::PH_HUNT;
            cmd_reg   <= '0;
            sum_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            word_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            word_reg  <= word_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/command_frame_parser_core.sv
// Top level of the command frame parser: input register, frame state machine,
// length registers and result register. Depends on cfp_pkg, cfp_len_regs, cfp_frame_fsm.
//
// One received byte (or timeout marker) is taken per transaction and the block
// sustains one transaction per clock while no result is stalled. Each byte is
// held in the input register and then processed by the combinational parser
// update into the result register, so with the result register free a frame's
// result is presented once its checksum byte has passed the input register and
// the result register. While a result waits, the input register's byte waits
// too and item_ready drops; item_ready follows result_ready within the same cycle.
`default_nettype none

module command_frame_parser_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire cfp_pkg::item_t      item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output cfp_pkg::result_t         result,
    input  wire logic                cfg_we,
    input  wire cfp_pkg::cfg_index_t cfg_index,
    input  wire cfp_pkg::len_t       cfg_data
);

    logic               in_valid_reg;
    cfp_pkg::item_t     in_item_reg;
    logic               out_valid_reg;
    cfp_pkg::result_t   out_res_reg;
    logic               consume;
    logic [2:0]         len_cmd;
    cfp_pkg::len_t      len;
    cfp_pkg::step_out_t step_out;

    assign consume    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || consume;

    cfp_len_regs u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (len_cmd),
        .len       (len)
    );

    cfp_frame_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (consume),
        .item     (in_item_reg),
        .len_cmd  (len_cmd),
        .len      (len),
        .step_out (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (consume)
            begin
                out_valid_reg <= step_out.fire;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_item_reg <= item;
        end
        if (consume && step_out.fire)
        begin
            out_res_reg <= step_out.res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_res_reg;

endmodule

`default_nettype wire

FILE: rtl/cfp_checker.sv
// Port-level checks for command_frame_parser_core and the bind that attaches
// them. Depends on cfp_pkg and the top level's port list.
`default_nettype none

module cfp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire cfp_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire cfp_pkg::result_t result
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result transaction dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    a_command_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.command) < cfp_pkg::NUM_COMMANDS))
        else $error("result command out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && !item.mode, 2))
        else $error("result without a byte transaction two cycles earlier");

endmodule

bind command_frame_parser_core cfp_checker u_cfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
